[design/bmp8_pkg.sv]
// Shared types and constants for the 8-bit BMP stream decoder.
// Holds the screen geometry, the result kinds and the payload structs.
// No dependencies.
package bmp8_pkg;

  // Screen geometry.
  localparam int SCREEN_WIDTH  = 320;
  localparam int SCREEN_HEIGHT = 200;

  // Bits needed to hold an image width of 0..SCREEN_WIDTH.
  localparam int WidthBits = $clog2(SCREEN_WIDTH + 1);

  // Framebuffer address of the first pixel of the bottom row.
  localparam logic [15:0] BottomRowBase = 16'((SCREEN_HEIGHT - 1) * SCREEN_WIDTH);

  // Kinds of result.
  typedef enum logic [1:0] {
    KIND_PALETTE = 2'd0,
    KIND_PIXEL   = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_e;

  // One input byte of the file.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_file;
  } bmp_in_t;

  // One result.
  typedef struct packed {
    logic [1:0]  result_kind;
    logic [15:0] target_index;
    logic [5:0]  red_level;
    logic [5:0]  green_level;
    logic [5:0]  blue_level;
    logic [7:0]  pixel_value;
    logic        image_done;
  } bmp_out_t;

  // A result leaving the parser, with its valid flag.
  typedef struct packed {
    logic     valid;
    bmp_out_t data;
  } bmp_res_t;

endpackage

[design/bmp8_parser.sv]
// Byte parser of the BMP decoder: header checks, palette assembly and
// framebuffer address generation. Depends on bmp8_pkg.
// Produces at most one result per accepted byte, combinationally.
module bmp8_parser import bmp8_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  bmp_in_t  in_data_i,
  output bmp_res_t res_o
);

  // Parse phases.
  localparam logic [2:0] PhHeader  = 3'd0;
  localparam logic [2:0] PhPalette = 3'd1;
  localparam logic [2:0] PhPixels  = 3'd2;
  localparam logic [2:0] PhDone    = 3'd3;
  localparam logic [2:0] PhError   = 3'd4;

  // Header byte positions that are checked.
  localparam logic [5:0] OfsSigB      = 6'd0;
  localparam logic [5:0] OfsSigM      = 6'd1;
  localparam logic [5:0] OfsDataLo    = 6'd10;
  localparam logic [5:0] OfsDataHi    = 6'd11;
  localparam logic [5:0] OfsInfoSize  = 6'd14;
  localparam logic [5:0] OfsWidthLo   = 6'd18;
  localparam logic [5:0] OfsWidthHi   = 6'd19;
  localparam logic [5:0] OfsWidthB2   = 6'd20;
  localparam logic [5:0] OfsWidthB3   = 6'd21;
  localparam logic [5:0] OfsHeightLo  = 6'd22;
  localparam logic [5:0] OfsHeightB1  = 6'd23;
  localparam logic [5:0] OfsHeightB2  = 6'd24;
  localparam logic [5:0] OfsHeightB3  = 6'd25;
  localparam logic [5:0] OfsBppLo     = 6'd28;
  localparam logic [5:0] OfsBppHi     = 6'd29;
  localparam logic [5:0] OfsCompB0    = 6'd30;
  localparam logic [5:0] OfsCompB1    = 6'd31;
  localparam logic [5:0] OfsCompB2    = 6'd32;
  localparam logic [5:0] OfsCompB3    = 6'd33;
  localparam logic [5:0] OfsHeaderEnd = 6'd53;

  localparam logic [7:0] SigB     = 8'h42;
  localparam logic [7:0] SigM     = 8'h4D;
  localparam logic [7:0] DataLo   = 8'h36;
  localparam logic [7:0] DataHi   = 8'h04;
  localparam logic [7:0] InfoSize = 8'h28;
  localparam logic [7:0] Bpp      = 8'd8;
  localparam logic [7:0] HeightLo = 8'(SCREEN_HEIGHT);
  localparam logic [7:0] LastRow  = 8'(SCREEN_HEIGHT - 1);

  logic [2:0]           phase_q, phase_d, phase_c;
  logic [5:0]           offset_q, offset_d, offset_c;
  logic [7:0]           width_lo_q, width_lo_d, width_lo_c;
  logic [WidthBits-1:0] width_q, width_d, width_c;
  logic [7:0]           blue_q, blue_d, blue_c;
  logic [7:0]           green_q, green_d, green_c;
  logic [7:0]           slot_q, slot_d, slot_c;
  logic [WidthBits-1:0] column_q, column_d, column_c;
  logic [7:0]           row_q, row_d, row_c;
  logic [15:0]          base_q, base_d, base_c;

  logic [7:0]           b;
  logic                 header_ok;
  logic [15:0]          width_full;
  logic [WidthBits-1:0] column_inc;

  assign b          = in_data_i.data_byte;
  assign width_full = {b, width_lo_c};
  assign column_inc = column_c + WidthBits'(1);

  // A start mark restarts the parser before the byte is taken.
  always_comb begin
    if (in_data_i.start_of_file) begin
      phase_c    = PhHeader;
      offset_c   = '0;
      width_lo_c = '0;
      width_c    = '0;
      blue_c     = '0;
      green_c    = '0;
      slot_c     = '0;
      column_c   = '0;
      row_c      = '0;
      base_c     = BottomRowBase;
    end else begin
      phase_c    = phase_q;
      offset_c   = offset_q;
      width_lo_c = width_lo_q;
      width_c    = width_q;
      blue_c     = blue_q;
      green_c    = green_q;
      slot_c     = slot_q;
      column_c   = column_q;
      row_c      = row_q;
      base_c     = base_q;
    end
  end

  // Header byte check at the current position; also captures the width.
  always_comb begin
    header_ok  = 1'b1;
    width_lo_d = width_lo_c;
    width_d    = width_c;
    unique case (offset_c)
      OfsSigB:     header_ok = (b == SigB);
      OfsSigM:     header_ok = (b == SigM);
      OfsDataLo:   header_ok = (b == DataLo);
      OfsDataHi:   header_ok = (b == DataHi);
      OfsInfoSize: header_ok = (b == InfoSize);
      OfsWidthLo:  width_lo_d = b;
      OfsWidthHi: begin
        header_ok = (width_full != 16'd0) && (width_full <= 16'(SCREEN_WIDTH));
        width_d   = width_full[WidthBits-1:0];
      end
      OfsHeightLo: header_ok = (b == HeightLo);
      OfsBppLo:    header_ok = (b == Bpp);
      OfsWidthB2, OfsWidthB3, OfsHeightB1, OfsHeightB2, OfsHeightB3,
      OfsBppHi, OfsCompB0, OfsCompB1, OfsCompB2, OfsCompB3:
        header_ok = (b == 8'd0);
      default:     header_ok = 1'b1;
    endcase
  end

  // Phase handling and result generation.
  always_comb begin
    phase_d  = phase_c;
    offset_d = offset_c;
    blue_d   = blue_c;
    green_d  = green_c;
    slot_d   = slot_c;
    column_d = column_c;
    row_d    = row_c;
    base_d   = base_c;
    res_o    = '0;
    unique case (phase_c)
      PhHeader: begin
        if (!header_ok) begin
          phase_d                 = PhError;
          res_o.valid             = 1'b1;
          res_o.data.result_kind  = KIND_ERROR;
        end else if (offset_c == OfsHeaderEnd) begin
          phase_d  = PhPalette;
          offset_d = '0;
        end else begin
          offset_d = offset_c + 6'd1;
        end
      end
      PhPalette: begin
        offset_d = {4'd0, offset_c[1:0] + 2'd1};
        unique case (offset_c[1:0])
          2'd0: blue_d  = b;
          2'd1: green_d = b;
          2'd2: begin
            res_o.valid             = 1'b1;
            res_o.data.result_kind  = KIND_PALETTE;
            res_o.data.target_index = {8'd0, slot_c};
            res_o.data.red_level    = b[7:2];
            res_o.data.green_level  = green_c[7:2];
            res_o.data.blue_level   = blue_c[7:2];
          end
          default: begin
            slot_d = slot_c + 8'd1;
            if (slot_c == 8'hFF) begin
              phase_d = PhPixels;
            end
          end
        endcase
      end
      PhPixels: begin
        res_o.valid             = 1'b1;
        res_o.data.result_kind  = KIND_PIXEL;
        res_o.data.target_index = base_c + 16'(column_c);
        res_o.data.pixel_value  = b;
        if (column_inc >= width_c) begin
          column_d = '0;
          row_d    = row_c + 8'd1;
          base_d   = base_c - 16'(SCREEN_WIDTH);
          if (row_c == LastRow) begin
            res_o.data.image_done = 1'b1;
            phase_d               = PhDone;
          end
        end else begin
          column_d = column_inc;
        end
      end
      default: begin
        // Image complete or header error: bytes are ignored until a restart.
      end
    endcase
  end

  // Parser state advances on every accepted byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhHeader;
      offset_q   <= '0;
      width_lo_q <= '0;
      width_q    <= '0;
      blue_q     <= '0;
      green_q    <= '0;
      slot_q     <= '0;
      column_q   <= '0;
      row_q      <= '0;
      base_q     <= BottomRowBase;
    end else if (accept_i) begin
      phase_q    <= phase_d;
      offset_q   <= offset_d;
      width_lo_q <= width_lo_d;
      width_q    <= width_d;
      blue_q     <= blue_d;
      green_q    <= green_d;
      slot_q     <= slot_d;
      column_q   <= column_d;
      row_q      <= row_d;
      base_q     <= base_d;
    end
  end

endmodule

[design/bmp8_out_reg.sv]
// Result register with a one-entry skid stage for the BMP decoder.
// Lets the input side keep going while a result waits. Depends on bmp8_pkg.
module bmp8_out_reg import bmp8_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  bmp_res_t res_i,
  output logic     full_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output bmp_out_t out_data_o
);

  logic     out_valid_q, out_valid_d;
  bmp_out_t out_data_q, out_data_d;
  logic     skid_valid_q, skid_valid_d;
  bmp_out_t skid_data_q, skid_data_d;

  // Hold the output while stalled; park a new result in the skid stage.
  always_comb begin
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    skid_valid_d = skid_valid_q;
    skid_data_d  = skid_data_q;
    if (out_valid_q && out_stall_i) begin
      if (res_i.valid) begin
        skid_valid_d = 1'b1;
        skid_data_d  = res_i.data;
      end
    end else if (skid_valid_q) begin
      out_valid_d  = 1'b1;
      out_data_d   = skid_data_q;
      skid_valid_d = 1'b0;
    end else begin
      out_valid_d = res_i.valid;
      out_data_d  = res_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

[design/bmp8_stream_to_framebuffer.sv]
// Top level of the 8-bit uncompressed BMP stream decoder.
// Depends on bmp8_pkg, bmp8_parser and bmp8_out_reg.
//
// Usage:
//   The input channel takes one file byte per transaction, with a start
//   mark on byte 0 of each file that restarts the parser. The output
//   channel carries one result per palette entry, one per pixel byte and
//   one on the first header byte that fails its check.
//   A result is registered at the edge that accepts its byte, so the
//   receiver can take it in the next cycle at the earliest. The block
//   takes one byte per cycle while in_stall_o is low; the parser state is a
//   set of counters updated on each accepted byte, so any byte may follow.
//   After reset the parser waits for byte 0 of a file and the output is
//   empty. When the receiver stalls, the waiting result is held and one more
//   result is parked in a skid register; in_stall_o rises only once that
//   register is occupied and falls at the edge where the receiver takes a
//   result. Row padding in the file is not skipped.
module bmp8_stream_to_framebuffer import bmp8_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  bmp_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output bmp_out_t out_data_o
);

  logic     accept;
  logic     full;
  bmp_res_t res;

  // A byte is taken whenever the skid register is free.
  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  bmp8_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_data_i (in_data_i),
    .res_o     (res)
  );

  // Only results of accepted bytes enter the output stage.
  bmp_res_t res_gated;
  always_comb begin
    res_gated       = res;
    res_gated.valid = res.valid && accept;
  end

  bmp8_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res_gated),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

[verif/bmp8_checker.sv]
// Result checker for the 8-bit BMP stream decoder.
// Watches both channels, predicts each result from the accepted bytes and compares.
// Depends on bmp8_pkg.
`timescale 1ns / 1ps

module bmp8_checker import bmp8_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_stall_i,
  input  bmp_in_t  in_data_i,
  input  logic     out_valid_i,
  input  logic     out_stall_i,
  input  bmp_out_t out_data_i,
  output int       mismatches_o,
  output int       pending_o
);

  // Fixed header values of an 8-bit uncompressed file.
  localparam logic [7:0] SigB         = 8'h42;
  localparam logic [7:0] SigM         = 8'h4D;
  localparam logic [7:0] OffsetLo     = 8'h36;
  localparam logic [7:0] OffsetHi     = 8'h04;
  localparam logic [7:0] InfoSize     = 8'h28;
  localparam logic [7:0] BitsPerPixel = 8'd8;
  localparam int HeaderLen    = 54;
  localparam int PaletteLen   = 256;
  localparam int ReportLimit  = 10;

  typedef enum logic [2:0] {
    PHASE_HEADER,
    PHASE_PALETTE,
    PHASE_PIXELS,
    PHASE_DONE,
    PHASE_ERROR
  } phase_e;

  // Decoder state as seen by the predictor.
  phase_e      phase;
  logic [10:0] hdr_pos;
  logic [15:0] img_width;
  logic [7:0]  blue_hold;
  logic [7:0]  green_hold;
  logic [8:0]  pal_index;
  logic [8:0]  col;
  logic [7:0]  row;

  bmp_out_t expected_results[$];
  int       mismatches;

  task automatic restart_decoder();
    phase      = PHASE_HEADER;
    hdr_pos    = '0;
    img_width  = '0;
    blue_hold  = '0;
    green_hold = '0;
    pal_index  = '0;
    col        = '0;
    row        = '0;
  endtask

  // Advances the predicted state by one file byte and queues the result it causes.
  task automatic decode_byte(input bmp_in_t item);
    logic [7:0] b;
    logic [1:0] sub;
    logic       ok;
    bmp_out_t   res;
    int         addr;
    b   = item.data_byte;
    res = '0;
    if (item.start_of_file) restart_decoder();
    case (phase)
      PHASE_HEADER: begin
        ok = 1'b1;
        case (hdr_pos)
          11'd0:  ok = (b == SigB);
          11'd1:  ok = (b == SigM);
          11'd10: ok = (b == OffsetLo);
          11'd11: ok = (b == OffsetHi);
          11'd14: ok = (b == InfoSize);
          11'd18: img_width = {8'h00, b};
          11'd19: begin
            img_width[15:8] = b;
            ok = (img_width != 16'd0) && (img_width <= SCREEN_WIDTH);
          end
          11'd20, 11'd21, 11'd23, 11'd24, 11'd25, 11'd29,
          11'd30, 11'd31, 11'd32, 11'd33: ok = (b == 8'h00);
          11'd22: ok = (b == 8'(SCREEN_HEIGHT));
          11'd28: ok = (b == BitsPerPixel);
          default: ;
        endcase
        if (!ok) begin
          // The first bad header byte reports once, then the file is ignored.
          phase = PHASE_ERROR;
          res.result_kind = KIND_ERROR;
          expected_results.push_back(res);
        end else begin
          hdr_pos++;
          if (hdr_pos == 11'(HeaderLen)) begin
            phase   = PHASE_PALETTE;
            hdr_pos = '0;
          end
        end
      end
      PHASE_PALETTE: begin
        // Entries are blue, green, red, pad; the red byte completes the entry.
        sub = hdr_pos[1:0];
        hdr_pos = {9'd0, sub + 2'd1};
        case (sub)
          2'd0: blue_hold = b;
          2'd1: green_hold = b;
          2'd2: begin
            res.result_kind  = KIND_PALETTE;
            res.target_index = 16'(pal_index);
            res.red_level    = b[7:2];
            res.green_level  = green_hold[7:2];
            res.blue_level   = blue_hold[7:2];
            expected_results.push_back(res);
          end
          default: begin
            pal_index++;
            if (pal_index == 9'(PaletteLen)) begin
              pal_index = '0;
              phase     = PHASE_PIXELS;
            end
          end
        endcase
      end
      PHASE_PIXELS: begin
        // File rows run bottom-up on the screen.
        addr = (SCREEN_HEIGHT - 1 - int'(row)) * SCREEN_WIDTH + int'(col);
        res.result_kind  = KIND_PIXEL;
        res.target_index = 16'(addr);
        res.pixel_value  = b;
        col++;
        if (col >= img_width) begin
          col = '0;
          row++;
          if (row >= SCREEN_HEIGHT) begin
            res.image_done = 1'b1;
            phase = PHASE_DONE;
          end
        end
        expected_results.push_back(res);
      end
      default: ;
    endcase
  endtask

  // Results are checked before the byte of the same edge is predicted;
  // a result never leaves in the cycle its byte is taken.
  always @(posedge clk_i or negedge rst_ni) begin : scoreboard
    bmp_out_t want;
    if (!rst_ni) begin
      restart_decoder();
      expected_results.delete();
      mismatches = 0;
      mismatches_o <= 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= ReportLimit) begin
            $display("unexpected result: kind %0d index %0d pixel %0d",
                     out_data_i.result_kind, out_data_i.target_index,
                     out_data_i.pixel_value);
          end
        end else begin
          want = expected_results.pop_front();
          if (out_data_i.result_kind !== want.result_kind ||
              out_data_i.target_index !== want.target_index ||
              out_data_i.red_level !== want.red_level ||
              out_data_i.green_level !== want.green_level ||
              out_data_i.blue_level !== want.blue_level ||
              out_data_i.pixel_value !== want.pixel_value ||
              out_data_i.image_done !== want.image_done) begin
            mismatches++;
            if (mismatches <= ReportLimit) begin
              $display("result mismatch (expected/actual): kind %0d/%0d index %0d/%0d",
                       want.result_kind, out_data_i.result_kind,
                       want.target_index, out_data_i.target_index);
              $display("  red %0d/%0d green %0d/%0d blue %0d/%0d pixel %0d/%0d done %0d/%0d",
                       want.red_level, out_data_i.red_level,
                       want.green_level, out_data_i.green_level,
                       want.blue_level, out_data_i.blue_level,
                       want.pixel_value, out_data_i.pixel_value,
                       want.image_done, out_data_i.image_done);
            end
          end
        end
      end
      if (in_valid_i && !in_stall_i) decode_byte(in_data_i);
      mismatches_o <= mismatches;
      pending_o <= expected_results.size();
    end
  end

endmodule

[verif/tb.sv]
// Testbench top for the 8-bit BMP stream decoder: drives byte streams and stalls.
// Depends on bmp8_pkg, bmp8_checker and the bmp8_stream_to_framebuffer RTL.
`timescale 1ns / 1ps

module tb;
  import bmp8_pkg::*;

  localparam logic [7:0] SigB         = 8'h42;
  localparam logic [7:0] SigM         = 8'h4D;
  localparam logic [7:0] OffsetLo     = 8'h36;
  localparam logic [7:0] OffsetHi     = 8'h04;
  localparam logic [7:0] InfoSize     = 8'h28;
  localparam logic [7:0] BitsPerPixel = 8'd8;
  localparam int HeaderLen   = 54;
  localparam int PaletteLen  = 1024;
  localparam int NoFault     = -1;
  localparam int WholeFile   = -1;
  localparam int StallLimit  = 2000;
  localparam int DrainCycles = 20;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  bmp_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_stall_i;
  bmp_out_t out_data_o;
  int       mismatch_count;
  int       pending_count;
  int       idle_cycles;

  // Header positions that are checked on their own.
  int fault_pos [17] = '{0, 1, 10, 11, 14, 20, 21, 22, 23, 24, 25, 28, 29, 30, 31, 32, 33};
  // Widths that must be refused.
  int bad_width [4] = '{0, SCREEN_WIDTH + 1, 16'h0200, 16'hFFFF};

  // Sender pacing: stretches with no gaps alternate with gapped ones.
  int   pace_left = 0;
  logic pace_calm = 1'b0;

  bmp8_stream_to_framebuffer uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  bmp8_checker result_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_i   (out_data_o),
    .mismatches_o (mismatch_count),
    .pending_o    (pending_count)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Offers one byte after an optional gap and returns at the edge that takes it.
  task automatic send_byte(input logic [7:0] b, input logic sof);
    int gap;
    int r;
    if (pace_left == 0) begin
      pace_calm = ($urandom_range(0, 3) == 0);
      pace_left = $urandom_range(50, 400);
    end
    pace_left--;
    gap = 0;
    if (!pace_calm) begin
      r = $urandom_range(0, 99);
      if (r >= 96) gap = $urandom_range(8, 40);
      else if (r >= 75) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= '{data_byte: b, start_of_file: sof};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Sends one file of the given width, optionally with a corrupted header byte
  // or cut short, followed by bytes that should be ignored.
  task automatic send_file(input int width, input int bad_pos, input int cut_len,
                           input int tail_len);
    logic [7:0] hdr [HeaderLen];
    logic [7:0] b;
    int total;
    for (int i = 0; i < HeaderLen; i++) hdr[i] = 8'($urandom_range(0, 255));
    hdr[0]  = SigB;
    hdr[1]  = SigM;
    hdr[10] = OffsetLo;
    hdr[11] = OffsetHi;
    hdr[14] = InfoSize;
    hdr[18] = width[7:0];
    hdr[19] = width[15:8];
    hdr[20] = 8'h00;
    hdr[21] = 8'h00;
    hdr[22] = 8'(SCREEN_HEIGHT);
    for (int i = 23; i <= 25; i++) hdr[i] = 8'h00;
    hdr[28] = BitsPerPixel;
    for (int i = 29; i <= 33; i++) hdr[i] = 8'h00;
    if (bad_pos != NoFault) hdr[bad_pos] ^= 8'($urandom_range(1, 255));
    total = (cut_len == WholeFile) ? HeaderLen + PaletteLen + width * SCREEN_HEIGHT : cut_len;
    for (int n = 0; n < total; n++) begin
      b = (n < HeaderLen) ? hdr[n] : 8'($urandom_range(0, 255));
      send_byte(b, n == 0);
    end
    repeat (tail_len) send_byte(8'($urandom_range(0, 255)), 1'b0);
  endtask

  // Receiver: quiet, choppy and blocked stretches, plus one long hold-off
  // that fills the block while the sender keeps offering.
  initial begin
    int hold_at;
    int cyc;
    int span;
    int pct;
    int sel;
    logic held;
    out_stall_i <= 1'b0;
    hold_at = $urandom_range(150, 350);
    cyc = 0;
    held = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      sel = $urandom_range(0, 9);
      if (!held && cyc >= hold_at) begin
        held = 1'b1;
        span = $urandom_range(300, 400);
        pct  = 100;
      end else if (sel < 3) begin
        span = $urandom_range(10, 100);
        pct  = 0;
      end else if (sel < 9) begin
        span = $urandom_range(10, 60);
        pct  = 33;
      end else begin
        span = $urandom_range(15, 50);
        pct  = 100;
      end
      repeat (span) begin
        out_stall_i <= ($urandom_range(0, 99) < pct);
        @(posedge clk_i);
        cyc++;
      end
    end
  end

  // Watchdog: ends the run when no transaction happens for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("bmp8_stream_to_framebuffer test failed");
        $finish;
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    int pick;
    int w;
    int pos;
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i <= '0;
    idle_cycles = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Out of reset without a start mark: the first byte counts as byte 0,
    // and the file fails at the data offset.
    send_byte(SigB, 1'b0);
    send_byte(SigM, 1'b0);
    for (int i = 2; i < 10; i++) send_byte(8'($urandom_range(0, 255)), 1'b0);
    send_byte(OffsetLo ^ 8'h01, 1'b0);
    // Bytes after an error are ignored until a start mark.
    send_byte(8'hA5, 1'b0);
    send_byte(SigB, 1'b0);
    // Restarts that fail on the signature.
    send_byte(8'h00, 1'b1);
    send_byte(SigB, 1'b1);
    send_byte(SigM ^ 8'h80, 1'b0);
    send_byte(8'hFF, 1'b0);

    // Every refused width.
    foreach (bad_width[i]) send_file(bad_width[i], NoFault, 20 + $urandom_range(0, 4), 0);

    // Good headers cut short inside the palette, broken headers and refused widths.
    for (int ep = 0; ep < 8; ep++) begin
      pick = $urandom_range(0, 2);
      w = $urandom_range(1, SCREEN_WIDTH);
      if (ep == 0 || pick == 0) begin
        send_file(w, NoFault, $urandom_range(HeaderLen + 8, HeaderLen + 60), 0);
      end else if (pick == 1) begin
        pos = fault_pos[$urandom_range(0, 16)];
        send_file(w, pos, pos + 1 + $urandom_range(0, 4), 0);
      end else begin
        send_file(bad_width[$urandom_range(0, 3)], NoFault, 20 + $urandom_range(0, 4), 0);
      end
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("bmp8_stream_to_framebuffer test passed");
    end else begin
      $display("bmp8_stream_to_framebuffer test failed");
    end
    $finish;
  end

endmodule

[files.f]
design/bmp8_pkg.sv
design/bmp8_parser.sv
design/bmp8_out_reg.sv
design/bmp8_stream_to_framebuffer.sv
verif/bmp8_checker.sv
verif/tb.sv
